// File: design/binary_to_decimal_ascii_defines.svh
// assertion macros used by the top-level rtl
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define B2D_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while out of reset
`define B2D_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/b2d_pkg.sv
`default_nettype none

package b2d_pkg;

   // fixed field widths
   localparam int ValueWidth   = 32;
   localparam int CharWidth    = 6;
   localparam int RspDataWidth = 8;

   // decimal digit buffer: a 32-bit value has at most ten digits
   localparam int BcdDigits    = 10;
   localparam int NibbleWidth  = 4;
   localparam int BcdWidth     = BcdDigits * NibbleWidth;
   localparam int BcdIdxWidth  = $clog2(BcdDigits);

   // double dabble: input bits folded in per cycle
   localparam int BitsPerStep  = 4;
   localparam int DabbleSteps  = ValueWidth / BitsPerStep;
   localparam int StepCntWidth = $clog2(DabbleSteps);

   localparam logic [NibbleWidth-1:0] DabbleAdjustMin = 4'd5;
   localparam logic [NibbleWidth-1:0] DabbleAdjust    = 4'd3;
   localparam logic [CharWidth-1:0]   AsciiZero       = 6'd48;

   typedef logic [NibbleWidth-1:0] bcd_digit_type;

   // converter state
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_DONE  = 3'b100
   } dabble_state_type;

   // finished conversion offered to the digit emitter
   typedef struct packed {
      logic                valid;
      logic [BcdWidth-1:0] bcd;
   } conv_type;

endpackage

`default_nettype wire

// File: design/b2d_dabble.sv
`default_nettype none

module b2d_dabble
   import b2d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ValueWidth-1:0] req_value,
   output conv_type                   conv,
   input  wire logic                  conv_ready
);

   dabble_state_type          state_ff, state_in;
   logic [StepCntWidth-1:0]   cnt_ff, cnt_in;
   logic [ValueWidth-1:0]     bin_ff, bin_in;
   logic [BcdWidth-1:0]       bcd_ff, bcd_in;
   logic [ValueWidth-1:0]     bin_step;
   logic [BcdWidth-1:0]       bcd_step;

   // one shift-add-3 round per input bit, four bits per cycle
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int b = 0; b < BitsPerStep; b++) begin
         for (int d = 0; d < BcdDigits; d++) begin
            if (bcd_step[d*NibbleWidth +: NibbleWidth] >= DabbleAdjustMin) begin
               bcd_step[d*NibbleWidth +: NibbleWidth] =
                  bcd_step[d*NibbleWidth +: NibbleWidth] + DabbleAdjust;
            end
         end
         bcd_step = {bcd_step[BcdWidth-2:0], bin_step[ValueWidth-1]};
         bin_step = {bin_step[ValueWidth-2:0], 1'b0};
      end
   end

   // sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in   = req_value;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            bin_in = bin_step;
            bcd_in = bcd_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == StepCntWidth'(DabbleSteps - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (conv_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign conv.valid = (state_ff == ST_DONE);
   assign conv.bcd   = bcd_ff;

endmodule

`default_nettype wire

// File: design/b2d_emit.sv
`default_nettype none

module b2d_emit
   import b2d_pkg::*;
#(
   parameter int DIGIT_LIMIT = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire conv_type               conv,
   output logic                        conv_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [CharWidth-1:0]        rsp_char,
   output logic                        rsp_last
);

   localparam logic [BcdIdxWidth-1:0] LastIdx = BcdIdxWidth'(DIGIT_LIMIT - 1);

   bcd_digit_type            digits_ff [BcdDigits];
   logic                     busy_ff;
   logic [BcdIdxWidth-1:0]   idx_ff;
   logic                     rsp_valid_ff;
   logic [CharWidth-1:0]     rsp_char_ff;
   logic                     rsp_last_ff;
   logic [BcdIdxWidth-1:0]   top_idx;
   logic [BcdIdxWidth-1:0]   start_idx;
   logic                     out_free;
   logic                     load;
   bcd_digit_type            cur_digit;

   // highest nonzero digit, capped at the digit limit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < BcdDigits; i++) begin
         if (conv.bcd[i*NibbleWidth +: NibbleWidth] != '0) begin
            top_idx = BcdIdxWidth'(i);
         end
      end
      start_idx = (top_idx > LastIdx) ? LastIdx : top_idx;
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign conv_ready = !busy_ff;
   assign load       = conv.valid && !busy_ff;
   assign cur_digit  = digits_ff[idx_ff];

   // digit walk, most significant first
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && out_free && idx_ff == '0) begin
         busy_ff <= 1'b0;
      end
      if (load) begin
         idx_ff <= start_idx;
         for (int i = 0; i < BcdDigits; i++) begin
            digits_ff[i] <= conv.bcd[i*NibbleWidth +: NibbleWidth];
         end
      end else if (busy_ff && out_free && idx_ff != '0) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= busy_ff;
      end
      if (busy_ff && out_free) begin
         rsp_char_ff <= AsciiZero + CharWidth'(cur_digit);
         rsp_last_ff <= (idx_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/binary_to_decimal_ascii.sv
// flow: an accepted request goes through double dabble at 4 bits per cycle, then
// hand-off to the emitter and its output register before its first digit
// throughput: one digit per cycle while rsp_tready is high; a new request is taken once
// the converter has handed its last result on, which the emitter takes only when done with the digits before it
// reset: synchronous, active high; clears the converter and emitter control only
`default_nettype none

`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii
   import b2d_pkg::*;
#(
   parameter int MAX_DIGITS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [ValueWidth-1:0]   req_tdata,   // [31:0] value
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                         rsp_tlast    // last_digit
);

   localparam int DigitLimit = (MAX_DIGITS < 1) ? 1 :
                               (MAX_DIGITS > BcdDigits) ? BcdDigits : MAX_DIGITS;

   conv_type             conv;
   logic                 conv_ready;
   logic [CharWidth-1:0] rsp_char;

   // binary to bcd
   b2d_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_value  (req_tdata),
      .conv       (conv),
      .conv_ready (conv_ready)
   );

   // bcd digits to ascii stream
   b2d_emit #(
      .DIGIT_LIMIT (DigitLimit)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .conv       (conv),
      .conv_ready (conv_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(RspDataWidth - CharWidth){1'b0}}, rsp_char};

   // checks
   `B2D_ASSERT_NOW(a_digit_range, rsp_tvalid, (rsp_char >= 6'd48) && (rsp_char <= 6'd57), "digit out of range")
   `B2D_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "converter took a second request")
   `B2D_ASSERT_NEXT(a_conv_hold, conv.valid && !conv_ready, conv.valid && $stable(conv.bcd), "conversion result lost")

endmodule

`default_nettype wire
